FILE: design/rapq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rapq_pkg
// Shared types and codes for the range-add / point-query store.
// ----------------------------------------------------------------------------
package rapq_pkg;

  localparam int DW = 64;   // stored word width
  localparam int FW = 11;   // index field width
  localparam int AMW = 32;  // amount field width

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [DW-1:0] word_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

FILE: design/rapq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rapq_mem
// Single-port synchronous word memory with registered read.
// ----------------------------------------------------------------------------
module rapq_mem #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  rapq_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  input  rapq_pkg::word_t   wdata,
  output rapq_pkg::word_t   rdata
);
  import rapq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/range_add_point_query_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_point_query_tree_core
// Range-add / point-query store of ENTRIES signed 64-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind and the operand fields with start; the word is taken at a
//   rising edge where start is high and busy is low.  An add (kind 0) adds
//   amount over range_low..range_high (clipped to 1..ENTRIES) and returns
//   nothing.  A query (kind 1) returns the entry at position on value with
//   done high for exactly one cycle; the receiver cannot stall it.
//   State is a binary indexed tree of range deltas in one single-port
//   memory; each visited node takes a read state and an update state.
//   Tree walks, with L = floor(log2(ENTRIES)) + 1:
//     add   : a read and update per node, at most 2*L (two boundary walks).
//     query : a read and update per set bit of position, at most L; done
//             is high after the last node's update, when the next word can go.
//     empty or fully clipped range: no walk, busy stays low.
//     out-of-range position: done with value 0 in the next cycle.
//   After reset the block sweeps all ENTRIES + 1 memory words to zero, one
//   word per cycle, with busy high, before the first word is taken.
// ----------------------------------------------------------------------------
module range_add_point_query_tree_core #(
  parameter int ENTRIES = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [rapq_pkg::FW-1:0]            range_low,
  input  logic [rapq_pkg::FW-1:0]            range_high,
  input  logic signed [rapq_pkg::AMW-1:0]    amount,
  input  logic [rapq_pkg::FW-1:0]            position,
  output logic                               done,
  output logic signed [rapq_pkg::DW-1:0]     value
);
  import rapq_pkg::*;

  localparam int AW    = $clog2(ENTRIES + 1);
  localparam int IW    = $clog2(ENTRIES + 2);
  localparam int CW    = (IW + 1 > FW + 1) ? IW + 1 : FW + 1;
  localparam int DEPTH = ENTRIES + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  localparam logic [CW-1:0] N_C = CW'(ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(ENTRIES);

  logic [1:0]    state;
  logic [AW-1:0] clr;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx2;
  logic          second;
  logic          op;
  word_t         delta;
  word_t         acc;

  mem_ctl_t      mctl;
  logic [AW-1:0] maddr;
  word_t         mwdata;
  word_t         mrdata;

  logic [CW-1:0] lo_c, hi_c, pos_c, lowbit, idx_up, idx_dn;
  word_t         acc_next;

  assign lo_c   = (range_low == '0) ? CW'(1) : CW'(range_low);
  assign hi_c   = (CW'(range_high) > N_C) ? N_C : CW'(range_high);
  assign pos_c  = CW'(position);
  assign lowbit = idx & (~idx + CW'(1));
  assign idx_up = idx + lowbit;
  assign idx_dn = idx - lowbit;
  assign acc_next = acc + mrdata;

  assign busy = (state != ST_IDLE);

  always_comb begin
    mctl   = '0;
    maddr  = idx[AW-1:0];
    mwdata = mrdata + delta;
    case (state)
      ST_CLEAR: begin
        mctl.wr = 1'b1;
        maddr   = clr;
        mwdata  = '0;
      end
      ST_RD: begin
        mctl.rd = 1'b1;
      end
      ST_UPD: begin
        mctl.wr = (op == KIND_ADD);
      end
      default: begin
        mctl = '0;
      end
    endcase
  end

  rapq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .ctl  (mctl),
    .addr (maddr),
    .wdata(mwdata),
    .rdata(mrdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      clr    <= '0;
      done   <= 1'b0;
      second <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == LAST_A) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op <= kind;
            if (kind == KIND_ADD) begin
              // difference form: +amount at low end, -amount past high end
              if (lo_c <= hi_c) begin
                idx    <= lo_c;
                idx2   <= hi_c + CW'(1);
                second <= (hi_c < N_C);
                delta  <= {{(DW-AMW){amount[AMW-1]}}, amount};
                state  <= ST_RD;
              end
            end else begin
              if (pos_c != '0 && pos_c <= N_C) begin
                idx   <= pos_c;
                acc   <= '0;
                state <= ST_RD;
              end else begin
                done  <= 1'b1;
                value <= '0;
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (op == KIND_ADD) begin
            if (idx_up <= N_C) begin
              idx   <= idx_up;
              state <= ST_RD;
            end else if (second) begin
              second <= 1'b0;
              idx    <= idx2;
              delta  <= ~delta + word_t'(1);
              state  <= ST_RD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            // prefix sum: drop the lowest set bit each step
            if (idx_dn == '0) begin
              done  <= 1'b1;
              value <= acc_next;
              state <= ST_IDLE;
            end else begin
              acc   <= acc_next;
              idx   <= idx_dn;
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_UPD || $past(state) == ST_IDLE))
    else $error("result strobe from an unexpected state");

  a_upd_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |-> $past(state) == ST_RD)
    else $error("update without a preceding read");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |-> (idx != '0 && idx <= N_C))
    else $error("tree index out of range");

  a_no_start_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> busy)
    else $error("idle during clearing pass");

endmodule
